// File: hdl/lcm_pkg.sv
// shared types and constants for the lidar cone median speed limiter
// no dependencies
`default_nettype none
package lcm_pkg;

  localparam logic [15:0] NO_OBSTACLE = 16'hFFFF;
  localparam int          RANGE_W     = 16;
  localparam int          SPEED_W     = 12;
  localparam int          PROD_W      = RANGE_W + SPEED_W;
  localparam int          ADDR_W      = 5;

  typedef enum logic [2:0] {
    REG_CONE_HALF_ANGLE = 3'd0,
    REG_MIN_VALID_RANGE = 3'd1,
    REG_ROBOT_RADIUS    = 3'd2,
    REG_SLOW_ZONE       = 3'd3,
    REG_TIER_SLOW       = 3'd4,
    REG_TIER_NORMAL     = 3'd5,
    REG_TIER_FAST       = 3'd6,
    REG_SPEED_LEVEL     = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LEVEL_SLOW   = 2'd0,
    LEVEL_NORMAL = 2'd1,
    LEVEL_FAST   = 2'd2,
    LEVEL_SAT    = 2'd3
  } speed_level_t;

  typedef struct packed {
    logic [15:0]        cone_half_angle;
    logic [15:0]        min_valid_range_mm;
    logic [15:0]        robot_radius_mm;
    logic [15:0]        slow_zone_mm;
    logic [SPEED_W-1:0] speed_tier_slow;
    logic [SPEED_W-1:0] speed_tier_normal;
    logic [SPEED_W-1:0] speed_tier_fast;
    logic [1:0]         speed_level;
  } cfg_t;

endpackage
`default_nettype wire

// File: hdl/lcm_queue.sv
// two-entry queue of scan minima between front and back
// depends on lcm_pkg
`default_nettype none
module lcm_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [lcm_pkg::RANGE_W-1:0] wr_data,
  output logic                            q_full,
  input  wire logic                       rd_en,
  output logic [lcm_pkg::RANGE_W-1:0]     rd_data,
  output logic                            q_empty
);
  import lcm_pkg::*;

  logic [RANGE_W-1:0] mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  assign q_full  = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign rd_data = mem[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lcm_front.sv
// sample classifier: cone and validity check, running scan minimum
// depends on lcm_pkg; feeds lcm_queue
`default_nettype none
module lcm_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lcm_pkg::cfg_t               cfg,
  input  wire logic                        accept,
  input  wire logic signed [15:0]          sample_angle,
  input  wire logic [lcm_pkg::RANGE_W-1:0] range_mm,
  input  wire logic                        range_invalid,
  input  wire logic                        end_of_scan,
  output logic                             q_push,
  output logic [lcm_pkg::RANGE_W-1:0]      q_data
);
  import lcm_pkg::*;

  logic [RANGE_W-1:0] min_r, min_nxt;
  logic [16:0]        mag;
  logic               counted;
  logic [RANGE_W-1:0] cand;

  always_comb begin
    mag = sample_angle[15] ? (17'(~sample_angle) + 17'd1) & 17'h1FFFF
                           : {1'b0, sample_angle};
    counted = (mag <= {1'b0, cfg.cone_half_angle}) && !range_invalid &&
              (range_mm > cfg.min_valid_range_mm);
    cand    = (counted && (range_mm < min_r)) ? range_mm : min_r;
    q_push  = accept && end_of_scan;
    q_data  = cand;
    min_nxt = min_r;
    if (accept) begin
      min_nxt = end_of_scan ? NO_OBSTACLE : cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= NO_OBSTACLE;
    end else begin
      min_r <= min_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lcm_back.sv
// scan history, median selection, speed rule with serial divider, result register
// depends on lcm_pkg; drains lcm_queue
`default_nettype none
module lcm_back #(
  parameter int HISTORY_DEPTH = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lcm_pkg::cfg_t               cfg,
  input  wire logic                        q_empty,
  input  wire logic [lcm_pkg::RANGE_W-1:0] q_data,
  output logic                             q_pop,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [lcm_pkg::RANGE_W-1:0]      out_obstacle_mm,
  output logic                             out_path_clear,
  output logic [lcm_pkg::SPEED_W-1:0]      out_allowed_speed,
  output logic                             out_blocked
);
  import lcm_pkg::*;

  localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_t;

  logic [RANGE_W-1:0] hist [HISTORY_DEPTH];
  logic               hist_we;

  state_t             state_r, state_nxt;
  logic [SW-1:0]      wslot_r, wslot_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [SW-1:0]      sel_r, sel_nxt;
  logic [RANGE_W-1:0] med_r, med_nxt;
  logic [RANGE_W-1:0] rem_r, rem_nxt;
  logic [SPEED_W-1:0] quo_r, quo_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [SPEED_W-1:0] spd_r, spd_nxt;
  logic               blk_r, blk_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RANGE_W-1:0] out_obs_r, out_obs_nxt;
  logic [SPEED_W-1:0] out_spd_r, out_spd_nxt;
  logic               out_blk_r, out_blk_nxt;

  logic [RANGE_W-1:0] cand;
  logic [CW-1:0]      lt_cnt, le_cnt, mid;
  logic [SPEED_W-1:0] tier;
  logic [RANGE_W-1:0] gap;
  logic [PROD_W-1:0]  prod;
  logic [RANGE_W:0]   trial;
  logic               ge;

  assign empty             = !out_valid_r;
  assign out_obstacle_mm   = out_obs_r;
  assign out_path_clear    = (out_obs_r == NO_OBSTACLE);
  assign out_allowed_speed = out_spd_r;
  assign out_blocked       = out_blk_r;

  // rank of the candidate entry among the filled entries
  always_comb begin
    cand   = hist[sel_r];
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < HISTORY_DEPTH; j++) begin
      if (CW'(j) < count_r) begin
        if (hist[j] < cand) begin
          lt_cnt = lt_cnt + CW'(1);
        end
        if (hist[j] <= cand) begin
          le_cnt = le_cnt + CW'(1);
        end
      end
    end
    mid = count_r >> 1;
  end

  always_comb begin
    case (speed_level_t'(cfg.speed_level))
      LEVEL_SLOW:   tier = cfg.speed_tier_slow;
      LEVEL_NORMAL: tier = cfg.speed_tier_normal;
      default:      tier = cfg.speed_tier_fast;
    endcase
    gap   = med_r - cfg.robot_radius_mm;
    prod  = PROD_W'(tier) * PROD_W'(gap);
    trial = {rem_r, quo_r[SPEED_W-1]};
    ge    = (trial >= {1'b0, cfg.slow_zone_mm});
  end

  always_comb begin
    state_nxt     = state_r;
    wslot_nxt     = wslot_r;
    count_nxt     = count_r;
    sel_nxt       = sel_r;
    med_nxt       = med_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    spd_nxt       = spd_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r && !pop;
    out_obs_nxt   = out_obs_r;
    out_spd_nxt   = out_spd_r;
    out_blk_nxt   = out_blk_r;
    q_pop         = 1'b0;
    hist_we       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          hist_we   = 1'b1;
          wslot_nxt = (wslot_r == SW'(HISTORY_DEPTH - 1)) ? '0 : wslot_r + SW'(1);
          if (count_r < CW'(HISTORY_DEPTH)) begin
            count_nxt = count_r + CW'(1);
          end
          sel_nxt   = '0;
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        if ((lt_cnt <= mid) && (mid < le_cnt)) begin
          med_nxt   = cand;
          state_nxt = ST_CALC;
        end else begin
          sel_nxt = sel_r + SW'(1);
        end
      end
      ST_CALC: begin
        blk_nxt   = 1'b0;
        spd_nxt   = tier;
        state_nxt = ST_OUT;
        if (med_r == NO_OBSTACLE) begin
          spd_nxt = tier;
        end else if (med_r <= cfg.robot_radius_mm) begin
          spd_nxt = '0;
          blk_nxt = 1'b1;
        end else if ((gap >= cfg.slow_zone_mm) || (cfg.slow_zone_mm == '0)) begin
          spd_nxt = tier;
        end else begin
          rem_nxt   = prod[PROD_W-1:SPEED_W];
          quo_nxt   = prod[SPEED_W-1:0];
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? RANGE_W'(trial - {1'b0, cfg.slow_zone_mm}) : trial[RANGE_W-1:0];
        quo_nxt  = {quo_r[SPEED_W-2:0], ge};
        step_nxt = step_r + 4'd1;
        if (step_r == 4'(SPEED_W - 1)) begin
          spd_nxt   = {quo_r[SPEED_W-2:0], ge};
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt = 1'b1;
          out_obs_nxt   = med_r;
          out_spd_nxt   = spd_r;
          out_blk_nxt   = blk_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[wslot_r] <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wslot_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wslot_r     <= wslot_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sel_r     <= sel_nxt;
    med_r     <= med_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    step_r    <= step_nxt;
    spd_r     <= spd_nxt;
    blk_r     <= blk_nxt;
    out_obs_r <= out_obs_nxt;
    out_spd_r <= out_spd_nxt;
    out_blk_r <= out_blk_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/lidar_cone_median_speed_limit_top.sv
// lidar front-cone obstacle filter and speed limiter, top level with config registers
// samples: one item per cycle while full is low; an end-of-scan item's minimum passes through
// the queue, the rank search and, when the speed rule needs it, the 12-step divider into the result register
// back end handles one scan at a time; two queued minima, then push stalls
// reset (rst_n low, synchronous) restores register defaults, clears the scan minimum,
// history count and queues; history contents are not cleared
`default_nettype none
module lidar_cone_median_speed_limit_top #(
  parameter int HISTORY_DEPTH = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lcm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [15:0]          in_sample_angle,
  input  wire logic [15:0]                 in_range_mm,
  input  wire logic                        in_range_invalid,
  input  wire logic                        in_end_of_scan,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [15:0]                      out_obstacle_mm,
  output logic                             out_path_clear,
  output logic [11:0]                      out_allowed_speed,
  output logic                             out_blocked
);
  import lcm_pkg::*;

  cfg_t               cfg_r, cfg_nxt;
  logic               cfg_wr;
  cfg_idx_t           cfg_idx;
  logic               accept;
  logic               q_push, q_full, q_pop, q_empty;
  logic [RANGE_W-1:0] q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign full    = q_full;
  assign accept  = push && !q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_CONE_HALF_ANGLE: cfg_nxt.cone_half_angle    = pwdata[15:0];
        REG_MIN_VALID_RANGE: cfg_nxt.min_valid_range_mm = pwdata[15:0];
        REG_ROBOT_RADIUS:    cfg_nxt.robot_radius_mm    = pwdata[15:0];
        REG_SLOW_ZONE:       cfg_nxt.slow_zone_mm       = pwdata[15:0];
        REG_TIER_SLOW:       cfg_nxt.speed_tier_slow    = pwdata[SPEED_W-1:0];
        REG_TIER_NORMAL:     cfg_nxt.speed_tier_normal  = pwdata[SPEED_W-1:0];
        REG_TIER_FAST:       cfg_nxt.speed_tier_fast    = pwdata[SPEED_W-1:0];
        REG_SPEED_LEVEL:     cfg_nxt.speed_level        = pwdata[1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CONE_HALF_ANGLE: prdata = {16'd0, cfg_r.cone_half_angle};
      REG_MIN_VALID_RANGE: prdata = {16'd0, cfg_r.min_valid_range_mm};
      REG_ROBOT_RADIUS:    prdata = {16'd0, cfg_r.robot_radius_mm};
      REG_SLOW_ZONE:       prdata = {16'd0, cfg_r.slow_zone_mm};
      REG_TIER_SLOW:       prdata = {20'd0, cfg_r.speed_tier_slow};
      REG_TIER_NORMAL:     prdata = {20'd0, cfg_r.speed_tier_normal};
      REG_TIER_FAST:       prdata = {20'd0, cfg_r.speed_tier_fast};
      REG_SPEED_LEVEL:     prdata = {30'd0, cfg_r.speed_level};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cone_half_angle    <= 16'd10923;
      cfg_r.min_valid_range_mm <= 16'd10;
      cfg_r.robot_radius_mm    <= 16'd105;
      cfg_r.slow_zone_mm       <= 16'd500;
      cfg_r.speed_tier_slow    <= 12'd100;
      cfg_r.speed_tier_normal  <= 12'd220;
      cfg_r.speed_tier_fast    <= 12'd500;
      cfg_r.speed_level        <= LEVEL_NORMAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .sample_angle  (in_sample_angle),
    .range_mm      (in_range_mm),
    .range_invalid (in_range_invalid),
    .end_of_scan   (in_end_of_scan),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  lcm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  lcm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .out_obstacle_mm   (out_obstacle_mm),
    .out_path_clear    (out_path_clear),
    .out_allowed_speed (out_allowed_speed),
    .out_blocked       (out_blocked)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("scan minimum pushed into full queue");

  a_blocked_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_blocked) |-> (out_allowed_speed == '0) && !out_path_clear)
    else $error("blocked item with nonzero speed or clear path");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end drained an empty queue");

endmodule
`default_nettype wire

// File: bench/tb_lidar_cone_median_speed_limit_top.sv
`timescale 1ns / 1ps
// self-checking bench for the lidar cone median speed limiter: directed and random scans,
// register writes between phases, results compared against a built-in predictor
// depends on hdl/lcm_pkg.sv and hdl/lidar_cone_median_speed_limit_top.sv
module tb_lidar_cone_median_speed_limit_top;
  import lcm_pkg::*;

  localparam int HIST_DEPTH    = 3;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct {
    logic signed [15:0] angle;
    logic [15:0]        range_mm;
    logic               invalid;
    logic               eos;
  } sample_t;

  typedef struct {
    logic [15:0] obstacle_mm;
    logic        path_clear;
    logic [11:0] speed;
    logic        blocked;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] in_sample_angle = '0;
  logic [15:0] in_range_mm = '0;
  logic in_range_invalid = 1'b0;
  logic in_end_of_scan = 1'b0;
  logic pop = 1'b0;
  logic empty;
  logic [15:0] out_obstacle_mm;
  logic out_path_clear;
  logic [11:0] out_allowed_speed;
  logic out_blocked;

  cfg_t        speed_cfg;
  logic [15:0] scan_min;
  logic [15:0] hist [HIST_DEPTH];
  int          hist_count;
  int          hist_slot;

  sample_t  pending_samples [$];
  verdict_t expected_verdicts [$];
  sample_t  on_wire;
  int       samples_in_flight = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       fail_count = 0;
  int       cycle_cnt = 0;

  lidar_cone_median_speed_limit_top #(.HISTORY_DEPTH(HIST_DEPTH)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .in_sample_angle  (in_sample_angle),
    .in_range_mm      (in_range_mm),
    .in_range_invalid (in_range_invalid),
    .in_end_of_scan   (in_end_of_scan),
    .pop              (pop),
    .empty            (empty),
    .out_obstacle_mm  (out_obstacle_mm),
    .out_path_clear   (out_path_clear),
    .out_allowed_speed(out_allowed_speed),
    .out_blocked      (out_blocked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit predict_sample(input sample_t s, output verdict_t v);
    int          mag;
    logic [11:0] tier;
    logic [15:0] filt_mm;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] gap;
    logic [27:0] prod;
    logic [27:0] quot;
    mag = (s.angle < 0) ? -int'(s.angle) : int'(s.angle);
    if (mag <= int'(speed_cfg.cone_half_angle) && !s.invalid &&
        s.range_mm > speed_cfg.min_valid_range_mm && s.range_mm < scan_min)
      scan_min = s.range_mm;
    v = '{default: '0};
    if (!s.eos) return 1'b0;
    hist[hist_slot] = scan_min;
    hist_slot = (hist_slot + 1) % HIST_DEPTH;
    if (hist_count < HIST_DEPTH) hist_count++;
    scan_min = NO_OBSTACLE;
    lo = (hist[0] < hist[1]) ? hist[0] : hist[1];
    hi = (hist[0] < hist[1]) ? hist[1] : hist[0];
    case (hist_count)
      1: filt_mm = hist[0];
      2: filt_mm = hi;
      default: filt_mm = (hi < hist[2]) ? hi : ((lo > hist[2]) ? lo : hist[2]);
    endcase
    case (speed_level_t'(speed_cfg.speed_level))
      LEVEL_SLOW:   tier = speed_cfg.speed_tier_slow;
      LEVEL_NORMAL: tier = speed_cfg.speed_tier_normal;
      default:      tier = speed_cfg.speed_tier_fast;
    endcase
    v.obstacle_mm = filt_mm;
    v.path_clear = (filt_mm == NO_OBSTACLE);
    if (filt_mm == NO_OBSTACLE) begin
      v.speed = tier;
    end else if (filt_mm <= speed_cfg.robot_radius_mm) begin
      v.speed = '0;
      v.blocked = 1'b1;
    end else begin
      gap = filt_mm - speed_cfg.robot_radius_mm;
      if (speed_cfg.slow_zone_mm == 0 || gap >= speed_cfg.slow_zone_mm) begin
        v.speed = tier;
      end else begin
        prod = tier * gap;
        quot = prod / speed_cfg.slow_zone_mm;
        v.speed = quot[11:0];
      end
    end
    return 1'b1;
  endfunction

  // sample driver: bursts of items with random gaps
  always @(posedge clk) begin : sample_driver
    verdict_t v;
    logic taken;
    taken = push && !full;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (taken) begin
        if (predict_sample(on_wire, v)) expected_verdicts.insert(expected_verdicts.size(), v);
        samples_in_flight--;
      end
      if (!push || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          on_wire = pending_samples[0];
          pending_samples.delete(0);
          in_sample_angle <= on_wire.angle;
          in_range_mm <= on_wire.range_mm;
          in_range_invalid <= on_wire.invalid;
          in_end_of_scan <= on_wire.eos;
          push <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern
  always @(posedge clk) begin : result_monitor
    verdict_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no item expected: obstacle_mm %0d", out_obstacle_mm);
          fail_count++;
        end else begin
          want = expected_verdicts[0];
          expected_verdicts.delete(0);
          if (out_obstacle_mm !== want.obstacle_mm) begin
            $error("obstacle_mm: expected %0d, got %0d", want.obstacle_mm, out_obstacle_mm);
            fail_count++;
          end
          if (out_path_clear !== want.path_clear) begin
            $error("path_clear: expected %0d, got %0d", want.path_clear, out_path_clear);
            fail_count++;
          end
          if (out_allowed_speed !== want.speed) begin
            $error("allowed_speed: expected %0d, got %0d", want.speed, out_allowed_speed);
            fail_count++;
          end
          if (out_blocked !== want.blocked) begin
            $error("blocked: expected %0d, got %0d", want.blocked, out_blocked);
            fail_count++;
          end
        end
      end
      case (cycle_cnt[8:7])
        2'd0: pop <= 1'b1;
        2'd1: pop <= 1'($urandom_range(0, 1));
        2'd2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= (cycle_cnt[4:0] > 5'd20);
      endcase
    end
  end

  task automatic add_sample(input int angle, input int rng, input logic inv, input logic eos);
    sample_t s;
    s.angle = angle[15:0];
    s.range_mm = rng[15:0];
    s.invalid = inv;
    s.eos = eos;
    pending_samples.insert(pending_samples.size(), s);
    samples_in_flight++;
  endtask

  task automatic settle();
    while (samples_in_flight != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CONE_HALF_ANGLE: speed_cfg.cone_half_angle = val[15:0];
      REG_MIN_VALID_RANGE: speed_cfg.min_valid_range_mm = val[15:0];
      REG_ROBOT_RADIUS:    speed_cfg.robot_radius_mm = val[15:0];
      REG_SLOW_ZONE:       speed_cfg.slow_zone_mm = val[15:0];
      REG_TIER_SLOW:       speed_cfg.speed_tier_slow = val[11:0];
      REG_TIER_NORMAL:     speed_cfg.speed_tier_normal = val[11:0];
      REG_TIER_FAST:       speed_cfg.speed_tier_fast = val[11:0];
      default:             speed_cfg.speed_level = val[1:0];
    endcase
  endtask

  task automatic set_all(input int cone, input int minv, input int radius, input int slow,
                         input int t_slow, input int t_norm, input int t_fast,
                         input int lvl);
    apb_write(REG_CONE_HALF_ANGLE, cone);
    apb_write(REG_MIN_VALID_RANGE, minv);
    apb_write(REG_ROBOT_RADIUS, radius);
    apb_write(REG_SLOW_ZONE, slow);
    apb_write(REG_TIER_SLOW, t_slow);
    apb_write(REG_TIER_NORMAL, t_norm);
    apb_write(REG_TIER_FAST, t_fast);
    apb_write(REG_SPEED_LEVEL, lvl);
  endtask

  function automatic int pick_tier();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic roll_config();
    int cone;
    int minv;
    int radius;
    int slow;
    case ($urandom_range(0, 3))
      0: cone = 0;
      1: cone = 32768;
      2: cone = $urandom_range(0, 65535);
      default: cone = $urandom_range(2000, 20000);
    endcase
    case ($urandom_range(0, 3))
      0: minv = 0;
      1: minv = 65534;
      default: minv = $urandom_range(0, 200);
    endcase
    case ($urandom_range(0, 3))
      0: radius = 0;
      1: radius = 65534;
      default: radius = $urandom_range(0, 800);
    endcase
    case ($urandom_range(0, 4))
      0: slow = 0;
      1: slow = 65534;
      2: slow = 1;
      default: slow = $urandom_range(1, 2000);
    endcase
    set_all(cone, minv, radius, slow, pick_tier(), pick_tier(), pick_tier(),
            $urandom_range(0, 3));
  endtask

  task automatic queue_random_scans(input int n_items);
    int left;
    int scan_len;
    int r;
    int a;
    int cone_lim;
    int radius;
    int slow;
    left = n_items;
    radius = int'(speed_cfg.robot_radius_mm);
    slow = int'(speed_cfg.slow_zone_mm);
    cone_lim = (speed_cfg.cone_half_angle > 16'd32768) ? 32768 : speed_cfg.cone_half_angle;
    while (left > 0) begin
      scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      for (int k = 0; k < scan_len; k++) begin
        if ($urandom_range(0, 4) != 0) begin
          a = $urandom_range(0, cone_lim);
          if ($urandom_range(0, 1)) a = -a;
          if (a > 32767) a = -32768;
        end else begin
          a = int'($urandom_range(0, 65535)) - 32768;
        end
        case ($urandom_range(0, 5))
          0: r = int'(speed_cfg.min_valid_range_mm) + int'($urandom_range(0, 4)) - 2;
          1: r = radius + int'($urandom_range(0, 6)) - 3;
          2: r = radius + slow + int'($urandom_range(0, 6)) - 3;
          3: r = $urandom_range(0, 65535);
          4: r = $urandom_range(65534, 65535);
          default: r = radius + int'($urandom_range(0, 2 * slow + 10));
        endcase
        if (r < 0) r = 0;
        if (r > 65535) r = 65535;
        add_sample(a, r, $urandom_range(0, 9) == 0, k == scan_len - 1);
      end
      left -= scan_len;
    end
  endtask

  initial begin
    speed_cfg = '{cone_half_angle: 16'd10923, min_valid_range_mm: 16'd10,
                  robot_radius_mm: 16'd105, slow_zone_mm: 16'd500,
                  speed_tier_slow: 12'd100, speed_tier_normal: 12'd220,
                  speed_tier_fast: 12'd500, speed_level: 2'd1};
    scan_min = NO_OBSTACLE;
    hist = '{default: '0};
    hist_count = 0;
    hist_slot = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: empty scan, cone edges, range threshold, median, blocked
    add_sample(0, 500, 1'b1, 1'b1);
    add_sample(-32768, 300, 1'b0, 1'b0);
    add_sample(10923, 10, 1'b0, 1'b0);
    add_sample(-10923, 11, 1'b0, 1'b1);
    add_sample(10924, 50, 1'b0, 1'b0);
    add_sample(32767, 40, 1'b0, 1'b0);
    add_sample(5, 200, 1'b0, 1'b1);
    add_sample(0, 65535, 1'b0, 1'b1);
    add_sample(100, 105, 1'b0, 1'b0);
    add_sample(-1, 90, 1'b0, 1'b1);
    add_sample(0, 100, 1'b0, 1'b1);
    add_sample(0, 605, 1'b0, 1'b1);
    add_sample(0, 2000, 1'b0, 1'b1);
    settle();

    // full cone, zero slow zone, saturated speed level
    set_all(32768, 0, 0, 0, 0, 4095, 4095, LEVEL_SAT);
    add_sample(-32768, 1, 1'b0, 1'b1);
    add_sample(0, 0, 1'b0, 1'b1);
    settle();

    // zero-width cone, top thresholds, zero slow tier
    set_all(0, 65534, 65534, 65534, 0, 0, 4095, LEVEL_SLOW);
    add_sample(0, 65534, 1'b0, 1'b0);
    add_sample(1, 65535, 1'b0, 1'b0);
    add_sample(0, 65535, 1'b0, 1'b1);
    settle();

    // zero tier with a positive gap
    set_all(10923, 10, 0, 100, 0, 220, 500, LEVEL_SLOW);
    repeat (3) add_sample(0, 50, 1'b0, 1'b1);
    settle();

    repeat (8) begin
      roll_config();
      queue_random_scans(48);
      settle();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: lidar_cone_median_speed_limit_top.f
hdl/lcm_pkg.sv
hdl/lcm_queue.sv
hdl/lcm_front.sv
hdl/lcm_back.sv
hdl/lidar_cone_median_speed_limit_top.sv
bench/tb_lidar_cone_median_speed_limit_top.sv
